/* hdl/va2f_pkg.sv */
// ----------------------------------------------------------------------------
// va2f_pkg
// Format codes, lane modes and the integer / normalized-byte to float helpers
// used by the vertex attribute converter.
// ----------------------------------------------------------------------------
package va2f_pkg;

  localparam int unsigned OpW   = 5;
  localparam int unsigned WordW = 32;

  localparam logic [4:0] FMT_INT    = 5'd0;
  localparam logic [4:0] FMT_UINT   = 5'd1;
  localparam logic [4:0] FMT_FLOAT  = 5'd2;
  localparam logic [4:0] FMT_VEC2   = 5'd3;
  localparam logic [4:0] FMT_VEC3   = 5'd4;
  localparam logic [4:0] FMT_VEC4   = 5'd5;
  localparam logic [4:0] FMT_IVEC2  = 5'd6;
  localparam logic [4:0] FMT_IVEC3  = 5'd7;
  localparam logic [4:0] FMT_IVEC4  = 5'd8;
  localparam logic [4:0] FMT_UVEC2  = 5'd9;
  localparam logic [4:0] FMT_UVEC3  = 5'd10;
  localparam logic [4:0] FMT_UVEC4  = 5'd11;
  localparam logic [4:0] FMT_UNORM1 = 5'd12;
  localparam logic [4:0] FMT_UNORM2 = 5'd13;
  localparam logic [4:0] FMT_UNORM4 = 5'd14;
  localparam logic [4:0] FMT_SNORM1 = 5'd15;
  localparam logic [4:0] FMT_SNORM2 = 5'd16;
  localparam logic [4:0] FMT_SNORM4 = 5'd17;

  localparam logic [31:0] FP_ONE     = 32'h3F80_0000;
  localparam logic [31:0] FP_NEG_ONE = 32'hBF80_0000;

  typedef enum logic [2:0] {
    LM_ZERO,
    LM_PASS,
    LM_SINT,
    LM_UINT,
    LM_UNORM,
    LM_SNORM
  } lane_mode_t;

  typedef struct packed {
    lane_mode_t mode_x;
    lane_mode_t mode_y;
    lane_mode_t mode_z;
    logic       bad;
  } fmt_ctl_t;

  function automatic fmt_ctl_t decode_fmt(input logic [4:0] op);
    fmt_ctl_t c;
    c = '{mode_x: LM_ZERO, mode_y: LM_ZERO, mode_z: LM_ZERO, bad: 1'b0};
    case (op) inside
      FMT_INT:   c.mode_x = LM_SINT;
      FMT_UINT:  c.mode_x = LM_UINT;
      FMT_FLOAT: c.mode_x = LM_PASS;
      FMT_VEC2:  begin c.mode_x = LM_PASS; c.mode_y = LM_PASS; end
      FMT_VEC3, FMT_VEC4: begin
        c.mode_x = LM_PASS; c.mode_y = LM_PASS; c.mode_z = LM_PASS;
      end
      FMT_IVEC2: begin c.mode_x = LM_SINT; c.mode_y = LM_SINT; end
      FMT_IVEC3, FMT_IVEC4: begin
        c.mode_x = LM_SINT; c.mode_y = LM_SINT; c.mode_z = LM_SINT;
      end
      FMT_UVEC2: begin c.mode_x = LM_UINT; c.mode_y = LM_UINT; end
      FMT_UVEC3, FMT_UVEC4: begin
        c.mode_x = LM_UINT; c.mode_y = LM_UINT; c.mode_z = LM_UINT;
      end
      FMT_UNORM1: c.mode_x = LM_UNORM;
      FMT_UNORM2: begin c.mode_x = LM_UNORM; c.mode_y = LM_UNORM; end
      FMT_UNORM4: begin
        c.mode_x = LM_UNORM; c.mode_y = LM_UNORM; c.mode_z = LM_UNORM;
      end
      FMT_SNORM1: c.mode_x = LM_SNORM;
      FMT_SNORM2: begin c.mode_x = LM_SNORM; c.mode_y = LM_SNORM; end
      FMT_SNORM4: begin
        c.mode_x = LM_SNORM; c.mode_y = LM_SNORM; c.mode_z = LM_SNORM;
      end
      default: c.bad = 1'b1;
    endcase
    return c;
  endfunction

  // count of leading zeros, 32 when the word is zero
  function automatic logic [5:0] lzc32(input logic [31:0] v);
    logic [5:0] n;
    n = 6'd32;
    for (int i = 0; i < 32; i++) begin
      if (v[i]) n = 6'(31 - i);
    end
    return n;
  endfunction

  // magnitude to single, round to nearest even
  function automatic logic [31:0] int_to_fp(input logic sgn, input logic [31:0] mag);
    logic [5:0]  lz;
    logic [31:0] norm;
    logic        rnd;
    logic [24:0] mant;
    logic [7:0]  expo;
    lz   = lzc32(mag);
    norm = mag << lz[4:0];
    rnd  = norm[7] & ((|norm[6:0]) | norm[8]);
    mant = {1'b0, norm[31:8]} + 25'(rnd);
    expo = 8'd158 - {3'b000, lz[4:0]} + {7'd0, mant[24]};
    if (mag == 32'd0) return 32'd0;
    return {sgn, expo, mant[24] ? 23'd0 : mant[22:0]};
  endfunction

  // b / 255: the quotient is the byte repeated forever, so sticky is never zero
  function automatic logic [31:0] unorm8_to_fp(input logic [7:0] b);
    logic [5:0]  lz;
    logic [39:0] rep;
    logic [24:0] mant;
    logic [7:0]  expo;
    lz   = lzc32({b, 24'd0});
    rep  = {b, b, b, b, b} << lz[2:0];
    mant = {1'b0, rep[39:16]} + 25'(rep[15]);
    expo = 8'd126 - {5'd0, lz[2:0]} + {7'd0, mant[24]};
    if (b == 8'd0)   return 32'd0;
    if (b == 8'hFF)  return FP_ONE;
    return {1'b0, expo, mant[24] ? 23'd0 : mant[22:0]};
  endfunction

  // s / 127 clamped at -1: magnitude repeats in 7-bit groups
  function automatic logic [31:0] snorm8_to_fp(input logic [7:0] b);
    logic        neg;
    logic [7:0]  nb;
    logic [6:0]  m;
    logic [5:0]  lz;
    logic [41:0] rep;
    logic [24:0] mant;
    logic [7:0]  expo;
    neg  = b[7];
    nb   = 8'd0 - b;
    m    = neg ? nb[6:0] : b[6:0];
    lz   = lzc32({m, 25'd0});
    rep  = {m, m, m, m, m, m} << lz[2:0];
    mant = {1'b0, rep[41:18]} + 25'(rep[17]);
    expo = 8'd126 - {5'd0, lz[2:0]} + {7'd0, mant[24]};
    if (b == 8'h80 || b == 8'h81) return FP_NEG_ONE;
    if (m == 7'd0)   return 32'd0;
    if (m == 7'h7F)  return FP_ONE;
    return {neg, expo, mant[24] ? 23'd0 : mant[22:0]};
  endfunction

endpackage

/* hdl/va2f_in_if.sv */
// ----------------------------------------------------------------------------
// va2f_in_if
// Request channel: format code and three raw attribute words.
// ----------------------------------------------------------------------------
interface va2f_in_if;
  logic        valid;
  logic        ready;
  logic [4:0]  operation;
  logic [31:0] raw_word0;
  logic [31:0] raw_word1;
  logic [31:0] raw_word2;

  modport source (output valid, output operation, output raw_word0,
                  output raw_word1, output raw_word2, input ready);
  modport sink   (input valid, input operation, input raw_word0,
                  input raw_word1, input raw_word2, output ready);
endinterface

/* hdl/va2f_out_if.sv */
// ----------------------------------------------------------------------------
// va2f_out_if
// Result channel: three single-precision components and a format error flag.
// ----------------------------------------------------------------------------
interface va2f_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] out_x;
  logic [31:0] out_y;
  logic [31:0] out_z;
  logic        bad_format;

  modport source (output valid, output out_x, output out_y, output out_z,
                  output bad_format, input ready);
  modport sink   (input valid, input out_x, input out_y, input out_z,
                  input bad_format, output ready);
endinterface

/* hdl/va2f_lane.sv */
// ----------------------------------------------------------------------------
// va2f_lane
// One component converter: pass, signed/unsigned integer, unorm8 or snorm8.
// ----------------------------------------------------------------------------
module va2f_lane (
  input  va2f_pkg::lane_mode_t mode,
  input  logic [31:0]          word,
  input  logic [7:0]           byte_val,
  output logic [31:0]          fp
);
  import va2f_pkg::*;

  logic [31:0] neg_word;

  assign neg_word = 32'd0 - word;

  always_comb begin
    case (mode)
      LM_PASS:  fp = word;
      LM_SINT:  fp = int_to_fp(word[31], word[31] ? neg_word : word);
      LM_UINT:  fp = int_to_fp(1'b0, word);
      LM_UNORM: fp = unorm8_to_fp(byte_val);
      LM_SNORM: fp = snorm8_to_fp(byte_val);
      default:  fp = 32'd0;
    endcase
  end
endmodule

/* hdl/vertex_attribute_to_float3.sv */
// ----------------------------------------------------------------------------
// vertex_attribute_to_float3
// Vertex fetch format converter: raw attribute words to three floats.
//
//   channel  dir  handshake      payload
//   in_ch    in   valid/ready    operation, raw_word0..2
//   out_ch   out  valid/ready    out_x, out_y, out_z, bad_format
//
// One request per cycle unless out_ch stalls; each passes the input register,
// then the result register after the format conversion logic.
// rst_n clears both valid flags only; payload registers are not reset.
// A stalled result holds the pipe; in_ch.ready drops only when both
// stages are full and out_ch.ready is low.
// ----------------------------------------------------------------------------
module vertex_attribute_to_float3 (
  input  logic        clk,
  input  logic        rst_n,
  va2f_in_if.sink     in_ch,
  va2f_out_if.source  out_ch
);
  import va2f_pkg::*;

  logic        s1_v_r;
  logic [4:0]  op_r;
  logic [31:0] w0_r, w1_r, w2_r;

  logic        out_v_r;
  logic [31:0] x_r, y_r, z_r;
  logic        bad_r;

  logic        out_stall;
  fmt_ctl_t    ctl;
  logic [31:0] x_nxt, y_nxt, z_nxt;

  assign out_stall   = out_v_r && !out_ch.ready;
  assign in_ch.ready = !s1_v_r || !out_stall;
  assign ctl         = decode_fmt(op_r);

  va2f_lane u_lane_x (.mode(ctl.mode_x), .word(w0_r), .byte_val(w0_r[7:0]),   .fp(x_nxt));
  va2f_lane u_lane_y (.mode(ctl.mode_y), .word(w1_r), .byte_val(w0_r[15:8]),  .fp(y_nxt));
  va2f_lane u_lane_z (.mode(ctl.mode_z), .word(w2_r), .byte_val(w0_r[23:16]), .fp(z_nxt));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r  <= 1'b0;
      out_v_r <= 1'b0;
    end else begin
      if (in_ch.ready) begin
        s1_v_r <= in_ch.valid;
      end
      if (!out_stall) begin
        out_v_r <= s1_v_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.ready) begin
      op_r <= in_ch.operation;
      w0_r <= in_ch.raw_word0;
      w1_r <= in_ch.raw_word1;
      w2_r <= in_ch.raw_word2;
    end
    // advance converted result unless held
    if (!out_stall) begin
      x_r   <= x_nxt;
      y_r   <= y_nxt;
      z_r   <= z_nxt;
      bad_r <= ctl.bad;
    end
  end

  assign out_ch.valid      = out_v_r;
  assign out_ch.out_x      = x_r;
  assign out_ch.out_y      = y_r;
  assign out_ch.out_z      = z_r;
  assign out_ch.bad_format = bad_r;
endmodule
